/* src/acia_pkg.sv */
`timescale 1ns / 1ps
// Package: word types, operation codes and control register bit positions for the ACIA block.
package acia_pkg;

  localparam logic [1:0] OP_BUS_READ  = 2'd0;
  localparam logic [1:0] OP_BUS_WRITE = 2'd1;
  localparam logic [1:0] OP_LINE_BYTE = 2'd2;
  localparam logic [1:0] OP_TIME_TICK = 2'd3;

  localparam logic SEL_STATUS_CTRL = 1'b0;
  localparam logic SEL_DATA        = 1'b1;

  // control register fields
  localparam int          CT_RXIE_BIT  = 7;
  localparam logic [1:0]  CT_TXCTL_IRQ = 2'b01;

  localparam logic [15:0] CHAR_TIME_RESET = 16'd1041;

  typedef struct packed {
    logic [1:0]  operation;
    logic        reg_select;
    logic [7:0]  data_byte;
    logic [11:0] tick_us;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } out_word_t;

  // interrupt request level from the status flags and the control register
  function automatic logic irq_level(logic rx_full, logic tx_empty, logic [7:0] ctl);
    irq_level = (rx_full && ctl[CT_RXIE_BIT]) || (tx_empty && (ctl[6:5] == CT_TXCTL_IRQ));
  endfunction

endpackage

/* src/acia_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (read-first).
module acia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/acia_uart_registers_unit.sv */
`timescale 1ns / 1ps
// Top level: MC6850-style ACIA register model with receive FIFO and microsecond timing.
//
// One word enters per cycle while the result side keeps up, and each word gives exactly
// one result word. A word is taken into an input register, and all its work (register
// updates, FIFO push or pop, countdowns, interrupt level) is done in the logic between
// that register and the result register. While an older result still waits, the input
// register can still take one new word if it is empty. Line bytes queue in a FIFO_DEPTH
// x 8 RAM with registered read; the head byte is kept in a register and the RAM keeps
// the byte behind it prefetched (with a bypass for a byte written in the same cycle),
// so a delivery tick can follow any other word in the next cycle. A byte arriving while
// the FIFO is full is dropped. The receive delivery moves one byte per character
// time into the holding register; a character time of zero counts as one. cfg_wdata is
// taken whenever cfg_we is high and should only be written while the block is idle.
module acia_uart_registers_unit
  import acia_pkg::*;
#(
  parameter int FIFO_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);

  // pipeline registers
  logic      in_vld_r;
  in_word_t  in_q_r;
  logic      out_vld_r;
  out_word_t out_q_r;
  logic      fire;

  // architectural state
  logic [15:0] char_time_r;
  logic [7:0]  control_r, control_nxt;
  logic        rx_full_r, rx_full_nxt;
  logic        tx_empty_r, tx_empty_nxt;
  logic [7:0]  rx_holding_r, rx_holding_nxt;
  logic [15:0] tx_cnt_r, tx_cnt_nxt;
  logic [15:0] rx_cnt_r, rx_cnt_nxt;

  // FIFO bookkeeping
  logic [AW-1:0] rd_slot_r, wr_slot_r;
  logic [AW-1:0] rd_inc, rd_inc2, wr_inc, ram_rd_addr;
  logic [CW-1:0] fifo_cnt_r;
  logic [7:0]    head_r;
  logic          byp_sel_r;
  logic [7:0]    byp_data_r;
  logic [7:0]    ram_rd_data;
  logic [7:0]    prefetch;
  logic          push, pop, push_en, pop_en;

  logic [15:0] char_eff;
  logic [15:0] tick16;
  logic [15:0] rx_left;
  logic [7:0]  status_cur;
  out_word_t   res;

  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  assign char_eff   = (char_time_r == 16'd0) ? 16'd1 : char_time_r;
  assign tick16     = {4'd0, in_q_r.tick_us};
  assign status_cur = {irq_level(rx_full_r, tx_empty_r, control_r), 5'd0, tx_empty_r, rx_full_r};

  // slot arithmetic wraps at FIFO_DEPTH
  assign rd_inc  = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;
  assign rd_inc2 = (rd_inc == LAST_SLOT) ? '0 : rd_inc + 1'b1;
  assign wr_inc  = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;

  assign push_en = fire && push;
  assign pop_en  = fire && pop;

  // keep the entry behind the head prefetched
  assign ram_rd_addr = pop_en ? rd_inc2 : rd_inc;
  assign prefetch    = byp_sel_r ? byp_data_r : ram_rd_data;

  // per-word work
  always_comb begin
    control_nxt    = control_r;
    rx_full_nxt    = rx_full_r;
    tx_empty_nxt   = tx_empty_r;
    rx_holding_nxt = rx_holding_r;
    tx_cnt_nxt     = tx_cnt_r;
    rx_cnt_nxt     = rx_cnt_r;
    rx_left        = rx_cnt_r;
    push           = 1'b0;
    pop            = 1'b0;
    res            = '0;
    unique case (in_q_r.operation)
      OP_BUS_READ: begin
        if (in_q_r.reg_select == SEL_STATUS_CTRL) begin
          res.read_data = status_cur;
        end else begin
          // data read returns the holding byte even if not full
          res.read_data = rx_holding_r;
          rx_full_nxt   = 1'b0;
        end
      end
      OP_BUS_WRITE: begin
        if (in_q_r.reg_select == SEL_STATUS_CTRL) begin
          control_nxt = in_q_r.data_byte;
        end else begin
          res.tx_valid = 1'b1;
          res.tx_byte  = in_q_r.data_byte;
          tx_cnt_nxt   = char_eff;
          tx_empty_nxt = 1'b0;
        end
      end
      OP_LINE_BYTE: begin
        push = (fifo_cnt_r != FULL_CNT);
      end
      OP_TIME_TICK: begin
        // transmit completion first, then receive delivery
        if (tx_cnt_r != 16'd0) begin
          tx_cnt_nxt = (tick16 >= tx_cnt_r) ? 16'd0 : tx_cnt_r - tick16;
          if (tx_cnt_nxt == 16'd0) begin
            tx_empty_nxt = 1'b1;
          end
        end
        rx_left    = (tick16 >= rx_cnt_r) ? 16'd0 : rx_cnt_r - tick16;
        rx_cnt_nxt = rx_left;
        if ((rx_left == 16'd0) && (fifo_cnt_r != '0)) begin
          pop            = 1'b1;
          rx_holding_nxt = head_r;
          rx_full_nxt    = 1'b1;
          rx_cnt_nxt     = char_eff;
        end
      end
      default: begin
      end
    endcase
    res.irq = irq_level(rx_full_nxt, tx_empty_nxt, control_nxt);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (fire) begin
      out_q_r <= res;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_time_r <= CHAR_TIME_RESET;
    end else if (cfg_we) begin
      char_time_r <= cfg_wdata;
    end
  end

  // register file and countdowns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r    <= '0;
      rx_full_r    <= 1'b0;
      tx_empty_r   <= 1'b1;
      rx_holding_r <= '0;
      tx_cnt_r     <= '0;
      rx_cnt_r     <= '0;
    end else if (fire) begin
      control_r    <= control_nxt;
      rx_full_r    <= rx_full_nxt;
      tx_empty_r   <= tx_empty_nxt;
      rx_holding_r <= rx_holding_nxt;
      tx_cnt_r     <= tx_cnt_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
    end
  end

  // FIFO pointers, count, head and bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r  <= '0;
      wr_slot_r  <= '0;
      fifo_cnt_r <= '0;
      byp_sel_r  <= 1'b0;
    end else begin
      if (push_en) begin
        wr_slot_r  <= wr_inc;
        fifo_cnt_r <= fifo_cnt_r + 1'b1;
      end else if (pop_en) begin
        rd_slot_r  <= rd_inc;
        fifo_cnt_r <= fifo_cnt_r - 1'b1;
      end
      byp_sel_r <= push_en && (wr_slot_r == ram_rd_addr);
    end
    byp_data_r <= in_q_r.data_byte;
    if (push_en && (fifo_cnt_r == '0)) begin
      head_r <= in_q_r.data_byte;
    end else if (pop_en) begin
      head_r <= prefetch;
    end
  end

  acia_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (wr_slot_r),
    .wr_data (in_q_r.data_byte),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FULL_CNT)
    else $error("rx fifo count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt_r == '0) |-> (rd_slot_r == wr_slot_r))
    else $error("empty fifo with unequal pointers");

  a_tx_clears_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_q_r.operation == OP_BUS_WRITE) && (in_q_r.reg_select == SEL_DATA))
    |=> (!tx_empty_r && (tx_cnt_r != 16'd0)))
    else $error("data write did not start transmit countdown");

  a_tx_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_q_r.tx_valid) |-> (out_q_r.read_data == 8'd0))
    else $error("transmit word with read data");

endmodule

/* tb/sv/acia_uart_registers_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for acia_uart_registers_unit: queued stimulus, predictor, result checks.
module acia_uart_registers_unit_test;
  import acia_pkg::*;

  localparam int FIFO_DEPTH  = 256;
  localparam int STALL_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int REPORT_MAX  = 10;

  // status and control bit positions as the bus sees them
  localparam int ST_RX_FULL  = 0;
  localparam int ST_TX_EMPTY = 1;
  localparam int ST_IRQ      = 7;
  localparam int TXCTL_HI    = 6;
  localparam int TXCTL_LO    = 5;
  localparam logic [7:0] STATUS_RESET = 8'h02;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  acia_uart_registers_unit #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the ACIA registers, countdowns and the
  // line receive queue. Updated once per accepted input word.
  // ---------------------------------------------------------------------------
  logic [15:0] char_us;          // character time as written, 0 reads as 1
  logic [7:0]  status_byte;
  logic [7:0]  control_byte;
  logic [7:0]  rx_data_byte;
  logic [15:0] tx_busy_us;
  logic [15:0] rx_wait_us;
  logic [7:0]  line_queue [FIFO_DEPTH];
  logic [8:0]  lq_rd;            // pointers wrap at twice the depth
  logic [8:0]  lq_wr;

  in_word_t  send_queue[$];      // words waiting for the driver
  out_word_t expected_results[$];
  out_word_t want;

  int  fault_count;
  int  quiet_cycles;
  int  gap_left;
  int  stall_left;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  in_taken;                 // set at the edge that accepts a word, cleared by the driver

  // IRQ bit of status follows RX full with RX interrupt enable, or TX empty
  // with transmit control 01.
  function automatic void update_irq_bit();
    status_byte[ST_IRQ] = (status_byte[ST_RX_FULL] && control_byte[CT_RXIE_BIT]) ||
                          (status_byte[ST_TX_EMPTY] &&
                           (control_byte[TXCTL_HI:TXCTL_LO] == CT_TXCTL_IRQ));
  endfunction

  // countdowns stop at zero rather than wrapping
  function automatic logic [15:0] count_down_us(logic [15:0] cnt, logic [11:0] us);
    return ({4'd0, us} >= cnt) ? 16'd0 : cnt - {4'd0, us};
  endfunction

  function automatic out_word_t acia_predict(in_word_t w);
    out_word_t   r;
    logic [15:0] ct;
    logic [8:0]  fill;
    r    = '0;
    ct   = (char_us == 16'd0) ? 16'd1 : char_us;
    fill = lq_wr - lq_rd;
    case (w.operation)
      OP_BUS_READ: begin
        if (w.reg_select == SEL_STATUS_CTRL) begin
          r.read_data = status_byte;
        end else begin
          // data read hands back the holding byte even when nothing new arrived
          r.read_data = rx_data_byte;
          status_byte[ST_RX_FULL] = 1'b0;
          update_irq_bit();
        end
      end
      OP_BUS_WRITE: begin
        if (w.reg_select == SEL_STATUS_CTRL) begin
          control_byte = w.data_byte;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte  = w.data_byte;
          tx_busy_us = ct;
          status_byte[ST_TX_EMPTY] = 1'b0;
        end
        update_irq_bit();
      end
      OP_LINE_BYTE: begin
        // full queue drops the byte silently
        if (fill != 9'(FIFO_DEPTH)) begin
          line_queue[lq_wr[7:0]] = w.data_byte;
          lq_wr = lq_wr + 9'd1;
        end
      end
      default: begin
        // transmit completion is handled before receive delivery
        if (tx_busy_us != 16'd0) begin
          tx_busy_us = count_down_us(tx_busy_us, w.tick_us);
          if (tx_busy_us == 16'd0) begin
            status_byte[ST_TX_EMPTY] = 1'b1;
            update_irq_bit();
          end
        end
        rx_wait_us = count_down_us(rx_wait_us, w.tick_us);
        if (rx_wait_us == 16'd0 && fill != 9'd0) begin
          rx_data_byte = line_queue[lq_rd[7:0]];
          lq_rd = lq_rd + 9'd1;
          status_byte[ST_RX_FULL] = 1'b1;
          update_irq_bit();
          rx_wait_us = ct;
        end
      end
    endcase
    r.irq = status_byte[ST_IRQ];
    return r;
  endfunction

  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Checker: everything sampled at the rising edge. The result side is checked
  // before the new prediction goes in so an early result cannot match a word
  // that was only accepted at this same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) char_us = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          log_fault($sformatf("unexpected word: rd=%02h irq=%0b txv=%0b txb=%02h",
                              out_data.read_data, out_data.irq, out_data.tx_valid,
                              out_data.tx_byte));
        end else begin
          want = expected_results.pop_front();
          if (want.read_data !== out_data.read_data || want.irq !== out_data.irq ||
              want.tx_valid !== out_data.tx_valid || want.tx_byte !== out_data.tx_byte) begin
            log_fault($sformatf({"mismatch: expected rd=%02h irq=%0b txv=%0b txb=%02h,",
                                 " got rd=%02h irq=%0b txv=%0b txb=%02h"},
                                want.read_data, want.irq, want.tx_valid, want.tx_byte,
                                out_data.read_data, out_data.irq, out_data.tx_valid,
                                out_data.tx_byte));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(acia_predict(in_data));
        in_taken = 1'b1;
      end
      // watchdog: a hung handshake on either side ends the run
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents the next queued word at the falling edge, holds it until
  // accepted, and now and then leaves a random gap before the next word.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rst_n && send_queue.size() != 0) begin
        in_data  <= send_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < send_idle_pct) gap_left = $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [1:0] op, logic sel, logic [7:0] byte_val, logic [11:0] us);
    in_word_t w;
    w.operation  = op;
    w.reg_select = sel;
    w.data_byte  = byte_val;
    w.tick_us    = us;
    send_queue.push_back(w);
  endtask

  // Random word with the given operation mix (percent); the rest are ticks.
  // Every field is random whatever the operation, so all bits toggle.
  function automatic in_word_t random_word(int pct_rd, int pct_wr, int pct_line);
    in_word_t w;
    int       pick;
    int       span;
    pick         = $urandom_range(0, 99);
    span         = $urandom_range(0, 9);
    w.reg_select = 1'($urandom_range(0, 1));
    w.data_byte  = 8'($urandom_range(0, 255));
    if (span == 0) w.tick_us = '0;
    else if (span < 5) w.tick_us = 12'($urandom_range(1, 64));
    else w.tick_us = 12'($urandom_range(0, 4095));
    if (pick < pct_rd) w.operation = OP_BUS_READ;
    else if (pick < pct_rd + pct_wr) w.operation = OP_BUS_WRITE;
    else if (pick < pct_rd + pct_wr + pct_line) w.operation = OP_LINE_BYTE;
    else w.operation = OP_TIME_TICK;
    return w;
  endfunction

  task automatic queue_random(int n, int pct_rd, int pct_wr, int pct_line);
    repeat (n) send_queue.push_back(random_word(pct_rd, pct_wr, pct_line));
  endtask

  // Idle means nothing queued, nothing presented and nothing outstanding.
  // Checked at the rising edge, where all of these are settled.
  task automatic wait_drained();
    do @(posedge clk);
    while (send_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Character time only changes with the block idle; every word returns a
  // result, so a short margin past the last result is enough.
  task automatic set_char_time(logic [15:0] us);
    wait_drained();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= us;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    fault_count   = 0;
    quiet_cycles  = 0;
    gap_left      = 0;
    stall_left    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_taken      = 1'b0;

    char_us      = CHAR_TIME_RESET;
    status_byte  = STATUS_RESET;
    control_byte = '0;
    rx_data_byte = '0;
    tx_busy_us   = '0;
    rx_wait_us   = '0;
    lq_rd        = '0;
    lq_wr        = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset values, every operation, field extremes, special cases
    send_idle_pct = 10;
    recv_idle_pct = 5;
    set_char_time(CHAR_TIME_RESET);
    push_word(OP_BUS_READ,  SEL_STATUS_CTRL, 8'h00, 12'd0);     // status after reset
    push_word(OP_BUS_READ,  SEL_DATA,        8'h00, 12'd0);     // data read, nothing received
    push_word(OP_BUS_WRITE, SEL_STATUS_CTRL, 8'h20, 12'd0);     // tx irq on, tx empty -> irq
    push_word(OP_BUS_READ,  SEL_STATUS_CTRL, 8'h00, 12'd0);     // irq shows in status
    push_word(OP_BUS_WRITE, SEL_DATA,        8'h00, 12'd0);     // send, tx empty drops
    push_word(OP_TIME_TICK, SEL_STATUS_CTRL, 8'h00, 12'd0);     // zero tick moves nothing
    push_word(OP_TIME_TICK, SEL_STATUS_CTRL, 8'h00, 12'd4095);  // tx countdown expires
    push_word(OP_BUS_WRITE, SEL_STATUS_CTRL, 8'h80, 12'd0);     // rx irq enable only
    push_word(OP_LINE_BYTE, SEL_STATUS_CTRL, 8'hFF, 12'd0);
    push_word(OP_LINE_BYTE, SEL_DATA,        8'h00, 12'd0);
    push_word(OP_TIME_TICK, SEL_STATUS_CTRL, 8'h00, 12'd0);     // zero tick still delivers
    push_word(OP_TIME_TICK, SEL_STATUS_CTRL, 8'h00, 12'd1040);  // one us short
    push_word(OP_TIME_TICK, SEL_STATUS_CTRL, 8'h00, 12'd1);     // delivery over unread byte
    push_word(OP_BUS_READ,  SEL_STATUS_CTRL, 8'h00, 12'd0);
    push_word(OP_BUS_READ,  SEL_DATA,        8'h00, 12'd0);     // clears rx full
    push_word(OP_BUS_READ,  SEL_DATA,        8'h00, 12'd0);     // stale holding byte
    push_word(OP_BUS_WRITE, SEL_DATA,        8'hFF, 12'd0);
    push_word(OP_BUS_WRITE, SEL_DATA,        8'hA5, 12'd0);     // restart while busy
    push_word(OP_TIME_TICK, SEL_DATA,        8'h00, 12'd1040);
    push_word(OP_TIME_TICK, SEL_DATA,        8'h00, 12'd1);     // exact expiry
    push_word(OP_BUS_WRITE, SEL_STATUS_CTRL, 8'hFF, 12'd0);     // all control bits
    push_word(OP_BUS_READ,  SEL_STATUS_CTRL, 8'h00, 12'd0);
    push_word(OP_BUS_WRITE, SEL_STATUS_CTRL, 8'h00, 12'd0);
    push_word(OP_TIME_TICK, SEL_STATUS_CTRL, 8'h00, 12'd4095);  // queue empty, nothing moves

    // zero character time behaves as one
    send_idle_pct = 20;
    recv_idle_pct = 8;
    set_char_time(16'd0);
    queue_random(130, 25, 25, 25);

    // stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_char_time(16'd1);
    queue_random(130, 25, 20, 30);

    // slowest character: countdowns span many ticks
    send_idle_pct = 40;
    recv_idle_pct = 15;
    set_char_time(16'hFFFF);
    queue_random(130, 20, 15, 20);

    // fill the line queue past full so bytes are dropped, then drain with ticks
    send_idle_pct = 15;
    recv_idle_pct = 10;
    set_char_time(16'd3);
    queue_random(262, 0, 0, 100);
    queue_random(200, 30, 10, 5);

    repeat (3) begin
      send_idle_pct = $urandom_range(0, 40);
      recv_idle_pct = $urandom_range(0, 15);
      set_char_time(16'($urandom_range(2, 4095)));
      queue_random(120, 25, 20, 25);
    end

    // final part runs with no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_char_time(16'($urandom_range(1, 200)));
    queue_random(150, 25, 20, 25);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
src/acia_pkg.sv
src/acia_ram.sv
src/acia_uart_registers_unit.sv
tb/sv/acia_uart_registers_unit_test.sv
